FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define FFBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/ffba_pkg.sv
package ffba_pkg;
	localparam int DEF_POOL_BYTES        = 65536;
	localparam int DEF_NODE_HEADER_BYTES = 16;
	localparam int DEF_POOL_HEADER_BYTES = 8;
	localparam int SIZE_W                = 17;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_ZERO     = 2'd2;
	localparam logic [1:0] ST_BAD_FREE = 2'd3;

	typedef struct packed {
		logic              used;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	// Saturate a requested pool size to [lo, hi].
	function automatic logic [SIZE_W-1:0] eff_pool(input logic [SIZE_W-1:0] p,
			input logic [SIZE_W-1:0] hi, input logic [SIZE_W-1:0] lo);
		logic [SIZE_W-1:0] r;
		r = p;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction
endpackage

FILE: rtl/ffba_hdr_mem.sv
module ffba_hdr_mem
	import ffba_pkg::*;
#(
	parameter int DEPTH  = DEF_POOL_BYTES,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wr_addr,
	input  hdr_t              wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output hdr_t              rd_data
);
	hdr_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

FILE: rtl/first_fit_block_allocator_unit.sv
// Sequence: an allocate walks the headers up to the first fit (one header read per cycle
// from the header memory), then writes the allocated tail header in S_SPLIT2 for a split.
// A free walks the headers up to the freed block, then merges in S_FNEXT; a rejected
// free and a zero-size allocate go straight to S_DONE.
// Throughput: one request at a time; the next request is taken once the result is out.
// Reset: usage clears, pool is 65536 bytes or POOL_BYTES if less; one write rebuilds the chain.
module first_fit_block_allocator_unit
	import ffba_pkg::*;
#(
	parameter int POOL_BYTES        = DEF_POOL_BYTES,
	parameter int NODE_HEADER_BYTES = DEF_NODE_HEADER_BYTES,
	parameter int POOL_HEADER_BYTES = DEF_POOL_HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [15:0] req_bytes,
	input  logic [15:0] block_addr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] grant_addr,
	output logic [16:0] used_bytes,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);
	`include "assert_macros.svh"

	// Block starts never reach the pool end, which is capped at 64 KiB.
	localparam int CAP    = (POOL_BYTES < 65536) ? POOL_BYTES : 65536;
	localparam int ADDR_W = $clog2(CAP);
	localparam logic [SIZE_W-1:0] CAP_V = SIZE_W'(CAP);
	localparam logic [SIZE_W-1:0] MIN_V = SIZE_W'(POOL_HEADER_BYTES + NODE_HEADER_BYTES);
	localparam logic [SIZE_W-1:0] NHB   = SIZE_W'(NODE_HEADER_BYTES);
	localparam logic [SIZE_W-1:0] PHB   = SIZE_W'(POOL_HEADER_BYTES);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WALK   = 3'd1;
	localparam logic [2:0] S_SPLIT2 = 3'd2;
	localparam logic [2:0] S_FNEXT  = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]        state_q;
	logic              rebuild_q;
	logic [SIZE_W-1:0] end_q, usage_q, cur_q, need_q, tail_q, prev_start_q;
	logic              op_q, has_prev_q, nxt_ok_q;
	logic [15:0]       addr_q, grant_q;
	logic [1:0]        status_q;
	hdr_t              prev_q, hit_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
	hdr_t              mem_wr_data, rd;

	ffba_hdr_mem #(.DEPTH(CAP), .ADDR_W(ADDR_W)) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (rd)
	);

	logic              in_acc;
	logic [SIZE_W:0]   sum, hdr_pos;
	logic              nxt_in, fit, split, hit, over;
	logic [SIZE_W-1:0] payload, rem_size, p_sz, n_sz, merged, base;

	assign in_stall = (state_q != S_IDLE) || rebuild_q;
	assign in_acc   = in_valid && !in_stall;

	// Walk datapath: next header start, fit and split tests on the header just read.
	assign sum      = {1'b0, cur_q} + {1'b0, rd.size};
	assign nxt_in   = sum < {1'b0, end_q};
	assign fit      = !rd.used && (rd.size >= need_q);
	assign split    = {1'b0, rd.size} > ({1'b0, need_q} + {1'b0, NHB});
	assign rem_size = rd.size - need_q;
	assign hdr_pos  = {1'b0, cur_q} + {1'b0, NHB};
	assign hit      = hdr_pos == {2'b00, addr_q};
	assign over     = hdr_pos > {2'b00, addr_q};
	assign payload  = ({1'b0, req_bytes} + SIZE_W'(3)) & ~SIZE_W'(3);

	// Merge of a freed block with its free neighbors.
	assign p_sz   = (has_prev_q && !prev_q.used) ? prev_q.size : '0;
	assign n_sz   = (nxt_ok_q && !rd.used) ? rd.size : '0;
	assign merged = p_sz + hit_q.size + n_sz;
	assign base   = (has_prev_q && !prev_q.used) ? prev_start_q : cur_q;

	// Read the first header on accept, else the header after the current one.
	assign mem_rd_addr = (state_q == S_IDLE) ? PHB[ADDR_W-1:0] : sum[ADDR_W-1:0];

	always_comb begin
		mem_we      = 1'b0;
		mem_wr_addr = PHB[ADDR_W-1:0];
		mem_wr_data = '{used: 1'b0, size: end_q - PHB};
		if (rebuild_q) begin
			mem_we = 1'b1;
		end else begin
			unique case (state_q)
				S_WALK: begin
					if (!op_q && fit) begin
						mem_we      = 1'b1;
						mem_wr_addr = cur_q[ADDR_W-1:0];
						mem_wr_data = split ? '{used: 1'b0, size: rem_size}
							: '{used: 1'b1, size: rd.size};
					end
				end
				S_SPLIT2: begin
					mem_we      = 1'b1;
					mem_wr_addr = tail_q[ADDR_W-1:0];
					mem_wr_data = '{used: 1'b1, size: need_q};
				end
				S_FNEXT: begin
					mem_we      = 1'b1;
					mem_wr_addr = base[ADDR_W-1:0];
					mem_wr_data = '{used: 1'b0, size: merged};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rebuild_q <= 1'b1;
			end_q     <= eff_pool(17'h10000, CAP_V, MIN_V);
			usage_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one is loaded this cycle.
			if (out_valid && !out_stall && state_q != S_DONE) out_valid <= 1'b0;
			// Rebuild the chain in the cycle after a pool size write.
			if (cfg_we) begin
				end_q     <= eff_pool(cfg_wdata, CAP_V, MIN_V);
				usage_q   <= '0;
				rebuild_q <= 1'b1;
			end else begin
				rebuild_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cur_q      <= PHB;
						has_prev_q <= 1'b0;
						if (!op && req_bytes == 16'd0) begin
							status_q <= ST_ZERO;
							grant_q  <= '0;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (!op_q) begin
						if (fit) begin
							status_q <= ST_OK;
							if (split) begin
								tail_q  <= cur_q + rem_size;
								grant_q <= 16'(cur_q + rem_size + NHB);
								usage_q <= usage_q + need_q;
								state_q <= S_SPLIT2;
							end else begin
								grant_q <= 16'(cur_q + NHB);
								usage_q <= usage_q + rd.size;
								state_q <= S_DONE;
							end
						end else if (!nxt_in) begin
							status_q <= ST_NO_FIT;
							grant_q  <= '0;
							state_q  <= S_DONE;
						end
					end else begin
						grant_q <= '0;
						if (hit && rd.used) begin
							hit_q    <= rd;
							nxt_ok_q <= nxt_in;
							status_q <= ST_OK;
							state_q  <= S_FNEXT;
						end else if (hit || over || !nxt_in) begin
							status_q <= ST_BAD_FREE;
							state_q  <= S_DONE;
						end
					end
					// Advance along the chain, holding the previous header for merge.
					if (!(op_q ? hit : fit) && nxt_in) begin
						cur_q        <= sum[SIZE_W-1:0];
						prev_q       <= rd;
						prev_start_q <= cur_q;
						has_prev_q   <= 1'b1;
					end
				end
				S_SPLIT2: state_q <= S_DONE;
				S_FNEXT: begin
					usage_q <= usage_q - hit_q.size;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid  <= 1'b1;
						status     <= status_q;
						grant_addr <= grant_q;
						used_bytes <= usage_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request payload on accept.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op;
			addr_q <= block_addr;
			need_q <= payload + NHB;
		end
	end

	`FFBA_ASSERT_NOW(a_usage_in_pool, state_q == S_IDLE, usage_q <= end_q, "usage beyond pool")
	`FFBA_ASSERT_NEXT(a_accept_busy, in_acc, state_q != S_IDLE, "accepted request not started")
	`FFBA_ASSERT_NOW(a_walk_in_pool, state_q == S_WALK, cur_q < end_q, "walk left the pool")
endmodule
